### src/mtg_pkg.sv
// Shared constants, types and functions of the MT19937-64 generator.
package mtg_pkg;

    localparam int STATE_WORDS   = 312;
    localparam int MIDDLE_OFFSET = 156;
    localparam int IDX_W         = $clog2(STATE_WORDS + 1);

    localparam logic [63:0] TW_MATRIX       = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_UPPER        = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TW_LOWER        = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TW_DEFAULT_SEED = 64'd5489;
    localparam logic [63:0] TW_SEED_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] TEMPER_B        = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_C        = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_D        = 64'hFFF7_EEE0_0000_0000;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] END_POS    = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] MID_IDX    = IDX_W'(MIDDLE_OFFSET);

    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_SEED = 1'b1;

    // One queued command from the front end to the engine.
    typedef struct packed {
        logic        is_seed;
        logic [63:0] seed;
    } mtg_cmd_t;

    function automatic logic [63:0] twist_one(input logic [63:0] hi_src,
                                              input logic [63:0] lo_src,
                                              input logic [63:0] tap);
        logic [63:0] x;
        logic [63:0] mag;
        x   = (hi_src & TW_UPPER) | (lo_src & TW_LOWER);
        mag = x[0] ? TW_MATRIX : 64'h0;
        return tap ^ (x >> 1) ^ mag;
    endfunction

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & TEMPER_B);
        x = x ^ ((x << 17) & TEMPER_C);
        x = x ^ ((x << 37) & TEMPER_D);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

### src/mtg_cmd_if.sv
// Command channel: valid, ready and one command item.
interface mtg_cmd_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] seed_value;

    modport source (output valid, output kind, output seed_value, input ready);
    modport sink (input valid, input kind, input seed_value, output ready);
endinterface

### src/mtg_word_if.sv
// Result channel: valid, ready and one random word item.
interface mtg_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

### src/mtg_front.sv
// Front end: accepts command items, classifies them and queues them.
module mtg_front
    import mtg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mtg_cmd_if.sink   command,
    output logic      cmd_valid,
    output mtg_cmd_t  cmd,
    input  logic      cmd_pop
);

    mtg_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign command.ready = (count_reg != 2'd2);
    assign push          = command.valid && command.ready;
    assign cmd_valid     = (count_reg != 2'd0);
    assign cmd           = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].is_seed <= (command.kind == KIND_SEED);
            entry_reg[wr_ptr_reg].seed    <= command.seed_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### src/mtg_engine.sv
// Back end: state memory, seeding, twisting, tempering and the result register.
module mtg_engine
    import mtg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  mtg_cmd_t  cmd,
    output logic      cmd_pop,
    mtg_word_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_MIX,
        S_SEED_MUL0,
        S_SEED_MUL1,
        S_SEED_MUL2,
        S_SEED_WR,
        S_TW_PRE,
        S_TW_ISSUE,
        S_TW_CALC,
        S_DRAW_RD,
        S_DRAW_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             seeded_reg, seeded_next;
    logic             pending_reg, pending_next;
    logic [63:0]      prev_reg, prev_next;
    logic [63:0]      mix_reg, mix_next;
    logic [63:0]      acc_reg, acc_next;
    logic [31:0]      cross_reg, cross_next;
    logic [63:0]      hold_reg, hold_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      out_word_reg, out_word_next;

    logic [63:0]      words [STATE_WORDS];
    logic [63:0]      rd_a_reg, rd_b_reg;
    logic             mem_we, rd_a_en, rd_b_en;
    logic [IDX_W-1:0] mem_wa, rd_a_addr, rd_b_addr;
    logic [63:0]      mem_wd;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [63:0]      seed_word;
    logic [63:0]      start_seed;
    logic             slot_free;

    assign mul_p      = {32'h0, mul_a} * {32'h0, mul_b};
    assign seed_word  = acc_reg + {cross_reg, 32'h0} + 64'(idx_reg);
    assign start_seed = cmd.is_seed ? cmd.seed : TW_DEFAULT_SEED;
    assign slot_free  = !out_valid_reg || result.ready;

    assign result.valid       = out_valid_reg;
    assign result.random_word = out_word_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            words[mem_wa] <= mem_wd;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= words[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= words[rd_b_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        seeded_next    = seeded_reg;
        pending_next   = pending_reg;
        prev_next      = prev_reg;
        mix_next       = mix_reg;
        acc_next       = acc_reg;
        cross_next     = cross_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_word_next  = out_word_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = idx_reg;
        mem_wd         = seed_word;
        rd_a_en        = 1'b0;
        rd_a_addr      = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        rd_b_en        = 1'b0;
        rd_b_addr      = (idx_reg < MID_IDX) ? idx_reg + MID_IDX : idx_reg - MID_IDX;
        mul_a          = mix_reg[31:0];
        mul_b          = TW_SEED_MULT[31:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_seed || !seeded_reg)
                    begin
                        // Word zero is the seed itself; the rest follow by recurrence.
                        mem_we       = 1'b1;
                        mem_wa       = '0;
                        mem_wd       = start_seed;
                        prev_next    = start_seed;
                        idx_next     = IDX_W'(1);
                        seeded_next  = 1'b1;
                        pos_next     = END_POS;
                        pending_next = !cmd.is_seed;
                        state_next   = S_SEED_MIX;
                    end
                    else if (pos_reg >= END_POS)
                    begin
                        state_next = S_TW_PRE;
                    end
                    else
                    begin
                        state_next = S_DRAW_RD;
                    end
                end
            end
            S_SEED_MIX:
            begin
                mix_next   = prev_reg ^ (prev_reg >> 62);
                state_next = S_SEED_MUL0;
            end
            S_SEED_MUL0:
            begin
                acc_next   = mul_p;
                state_next = S_SEED_MUL1;
            end
            S_SEED_MUL1:
            begin
                mul_a      = mix_reg[63:32];
                cross_next = mul_p[31:0];
                state_next = S_SEED_MUL2;
            end
            S_SEED_MUL2:
            begin
                mul_b      = TW_SEED_MULT[63:32];
                cross_next = cross_reg + mul_p[31:0];
                state_next = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                mem_we    = 1'b1;
                prev_next = seed_word;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next     = '0;
                    pending_next = 1'b0;
                    state_next   = pending_reg ? S_TW_PRE : S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SEED_MIX;
                end
            end
            S_TW_PRE:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = '0;
                idx_next   = '0;
                state_next = S_TW_ISSUE;
            end
            S_TW_ISSUE:
            begin
                // The first step takes old word zero from the read just done.
                if (idx_reg == '0)
                begin
                    hold_next = rd_a_reg;
                end
                rd_a_en    = 1'b1;
                rd_b_en    = 1'b1;
                state_next = S_TW_CALC;
            end
            S_TW_CALC:
            begin
                mem_we    = 1'b1;
                mem_wd    = twist_one(hold_reg, rd_a_reg, rd_b_reg);
                hold_next = rd_a_reg;
                if (idx_reg == LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = S_DRAW_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TW_ISSUE;
                end
            end
            S_DRAW_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = pos_reg;
                state_next = S_DRAW_OUT;
            end
            S_DRAW_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = temper(rd_a_reg);
                    pos_next       = pos_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pos_reg       <= END_POS;
            seeded_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            prev_reg      <= '0;
            mix_reg       <= '0;
            acc_reg       <= '0;
            cross_reg     <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            seeded_reg    <= seeded_next;
            pending_reg   <= pending_next;
            prev_reg      <= prev_next;
            mix_reg       <= mix_next;
            acc_reg       <= acc_next;
            cross_reg     <= cross_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= END_POS)
        else $error("read position beyond state size");

    a_draw_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW_RD) |-> (seeded_reg && (pos_reg < END_POS)))
        else $error("draw read from unseeded or exhausted state");

    a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TW_CALC && idx_reg == LAST_IDX)
        |=> (state_reg == S_DRAW_RD && pos_reg == '0))
        else $error("twist did not end in a draw from word zero");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DRAW_OUT))
        else $error("result raised outside the draw output step");
`endif

endmodule

### src/mt19937_64_generator_unit.sv
// Top level of the MT19937-64 generator: front end queue and generator engine.
//
//   channel   dir   handshake        payload
//   command   in    valid / ready    kind (1), seed_value (64)
//   result    out   valid / ready    random_word (64)
//
// A draw item runs in the engine's single sequencer over the 312-word state
// memory: it reads the next state word and tempers it into the result register.
// Every 312th draw first twists the whole state: one read of word zero, then
// two memory reads and one write per word.
// A seed item writes the seed as word zero and each later word by recurrence;
// one shared 32x32 multiplier forms each recurrence product in three passes.
// A draw before any seed pays this seeding with 5489 and then a twist.
// Reset clears the registers only; no clearing pass runs over the memory.
// A two-item queue lets command items arrive while the engine works, and the
// result register holds a word until it is taken, stalling only the engine.
module mt19937_64_generator_unit
    import mtg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mtg_cmd_if.sink    command,
    mtg_word_if.source result
);

    // Queued command handed from the front end to the engine.
    logic     cmd_valid;
    mtg_cmd_t cmd;
    logic     cmd_pop;

    // The front end classifies each item as seed or draw and queues it.
    mtg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // The engine owns the state memory and the result register.
    mtg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .result    (result)
    );

endmodule
